@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that holds at every clock edge outside reset
`define BPFC_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bpfc check failed");

// a condition that forces another one in the next cycle
`define BPFC_CHECK_NEXT(label, cond, nxt) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error("bpfc check failed");

`endif

@@ src/bpfc_pkg.sv @@
// types, codes and helper functions of the block presence filter
package bpfc_pkg;

   // default sizes
   localparam int DEF_MAX_BLOCKS = 65536;
   localparam int DEF_MAX_RANGES = 64;
   localparam int DEF_MAX_JOBS   = 4;

   // register reset values
   localparam logic [16:0] BPR_RESET = 17'd1024;
   localparam logic [16:0] BIU_RESET = 17'd65536;

   // register indexes
   localparam logic [3:0] CSR_BPR = 4'd0;
   localparam logic [3:0] CSR_BIU = 4'd1;

   typedef enum logic [3:0] {
      OP_QUERY    = 4'd0,
      OP_ADD      = 4'd1,
      OP_COUNT    = 4'd2,
      OP_START    = 4'd3,
      OP_FINISH   = 4'd4,
      OP_FAIL     = 4'd5,
      OP_UPDATE   = 4'd6,
      OP_GET_BASE = 4'd7,
      OP_SET_BASE = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_FULL    = 3'd3,
      ST_ORDER   = 3'd4,
      ST_MISSING = 3'd5
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_DIVIDE, S_MULT, S_CHECK,
      S_Q_READ, S_Q_EVAL, S_A_READ, S_A_EVAL, S_A_JOB, S_A_JOB_WR,
      S_C_READ, S_C_ACC, S_G_WAIT,
      S_F_RANGE, S_F_MULT, S_F_BOUND, S_F_READ, S_F_WRITE, S_F_MREAD, S_F_MWRITE,
      S_WIPE, S_UPDATE, S_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [15:0] first_block;
      logic [15:0] last_block;
      logic [15:0] block_index;
      logic [63:0] commit_id;
      logic [5:0]  range_index;
      logic [63:0] new_baseline;
      logic        list_last;
   } req_type;

   typedef struct packed {
      logic        answer_flag;
      logic [16:0] set_count;
      logic [63:0] baseline_out;
      logic        baseline_valid;
      status_type  status;
   } rsp_type;

   // bits lo..hi of a 64-bit word
   function automatic logic [63:0] span_mask(input logic [5:0] lo, input logic [5:0] hi);
      return ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
   endfunction

   // number of set bits in a word
   function automatic logic [6:0] pop_count(input logic [63:0] w);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         n = n + 7'(w[i]);
      end
      return n;
   endfunction

endpackage

@@ src/bpfc_ram.sv @@
// single write port, single read port ram with registered read data
module bpfc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a collision
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/bpfc_div.sv @@
// restoring divider, one quotient bit per cycle
module bpfc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [15:0] quotient,
   output logic [16:0] remainder
);

   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [16:0] dsr_ff, dsr_in;
   logic [17:0] trial;

   // one shift and subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[15]};
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         step_in = 5'd16;
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 17'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ src/block_presence_filter_with_compaction.sv @@
// top level of the block presence filter with compaction queue
//
// Requests arrive on req_valid/req_stall with one req_data word; each request
// gives exactly one result word on rsp_valid/rsp_stall. Registers are written
// on csr_valid/csr_ready (always ready); the user must write them only while
// no request is in flight; the block does not enforce it. One request is
// worked on at a time, as a sequence over the memories:
//   get/set/fail-empty: a check; update: a walk over the queued jobs; add:
//   a divide, a read-modify-write, a step per queued job and a write for
//   each that records the block; query: a divide and a walk over its blocks;
//   count: the bitmap words of the range; finish: every range slot and its
//   words, then every bitmap word; fail: every bitmap word.
// A finished result sits in an output register; the next request is taken
// while it waits. A stalled result holds until taken; a new result waits.
// After reset a clearing pass writes zero to every word of the presence and
// added-block rams, the latter holding a bitmap per job slot; requests stall
// meanwhile, register writes are still taken.
module block_presence_filter_with_compaction #(
   parameter int MAX_BLOCKS = bpfc_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_RANGES = bpfc_pkg::DEF_MAX_RANGES,
   parameter int MAX_JOBS   = bpfc_pkg::DEF_MAX_JOBS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpfc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [16:0]       csr_wdata
);

   localparam int NWORDS = (MAX_BLOCKS + 63) / 64;
   localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int RAW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int SW     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW     = $clog2(MAX_JOBS + 1);
   localparam int BW     = $clog2(MAX_BLOCKS + 1);
   localparam int EW     = (BW > 17) ? BW : 17;
   localparam int RIW    = $clog2(MAX_RANGES + 1);
   localparam int MIW    = (RIW > 6) ? RIW : 6;
   localparam int PW     = MIW + 18;
   localparam int TW     = SW + 1;
   localparam int CLW    = SW + WAW;

   bpfc_pkg::state_type  state_ff, state_in;
   bpfc_pkg::req_type    req_ff, req_in;
   bpfc_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 ans_ff, ans_in;
   logic [16:0]          cnt_ff, cnt_in;
   logic [63:0]          bout_ff, bout_in;
   logic                 bval_ff, bval_in;
   bpfc_pkg::status_type stat_ff, stat_in;
   logic [16:0]          bpr_ff, bpr_in;
   logic [16:0]          biu_ff, biu_in;
   logic [15:0]          blk_ff, blk_in;
   logic [15:0]          rr_ff, rr_in;
   logic [16:0]          off_ff, off_in;
   logic [MIW-1:0]       idx_ff, idx_in;
   logic [PW-1:0]        st_ff, st_in;
   logic [WAW-1:0]       wd_ff, wd_in;
   logic [WAW-1:0]       wend_ff, wend_in;
   logic [5:0]           lo6_ff, lo6_in;
   logic [5:0]           hi6_ff, hi6_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [CW-1:0]        jn_ff, jn_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [63:0]          newest_ff, newest_in;
   logic [MAX_RANGES-1:0] base_set_ff, base_set_in;
   logic                 list_open_ff, list_open_in;
   logic                 list_bad_ff, list_bad_in;
   logic [63:0]          list_commit_ff, list_commit_in;
   logic [MAX_RANGES-1:0] list_mask_ff, list_mask_in;
   logic [CLW-1:0]       clr_ff, clr_in;

   // compaction queue entries
   logic [63:0]           job_commit_ff [MAX_JOBS];
   logic [63:0]           job_base_ff [MAX_JOBS];
   logic [MAX_RANGES-1:0] job_mask_ff [MAX_JOBS];
   logic                  push_en, jbase_en;
   logic [63:0]           push_commit;
   logic [MAX_RANGES-1:0] push_mask;

   // memory ports
   logic           pres_we;
   logic [WAW-1:0] pres_wa, pres_ra;
   logic [63:0]    pres_wd, pres_rd;
   logic           add_we;
   logic [CLW-1:0] add_wa, add_ra;
   logic [63:0]    add_wd, add_rd;
   logic           base_we;
   logic [RAW-1:0] base_wa, base_ra;
   logic [63:0]    base_wd, base_rd;

   // divider
   logic        div_start, div_done;
   logic [15:0] div_dividend, div_quo;
   logic [16:0] div_rem;

   // derived values
   logic [16:0]    bpr_eff;
   logic [EW-1:0]  nblk;
   logic [PW-1:0]  prod, en_sum, en_c, sl_c, last_c;
   logic [TW-1:0]  tail_sum;
   logic [SW-1:0]  tail, slot_inc;
   logic           range_ok, last_job, cur_bit;
   logic [MAX_RANGES-1:0] r_onehot, lmask;
   logic           lbad;
   logic [63:0]    lcom;
   logic [63:0]    blk_onehot, cur_mask;

   bpfc_ram #(.DEPTH(1 << WAW), .WIDTH(64)) u_pres (
      .clock(clock), .wr_en(pres_we), .wr_addr(pres_wa), .wr_data(pres_wd),
      .rd_addr(pres_ra), .rd_data(pres_rd)
   );

   bpfc_ram #(.DEPTH(1 << CLW), .WIDTH(64)) u_added (
      .clock(clock), .wr_en(add_we), .wr_addr(add_wa), .wr_data(add_wd),
      .rd_addr(add_ra), .rd_data(add_rd)
   );

   bpfc_ram #(.DEPTH(1 << RAW), .WIDTH(64)) u_base (
      .clock(clock), .wr_en(base_we), .wr_addr(base_wa), .wr_data(base_wd),
      .rd_addr(base_ra), .rd_data(base_rd)
   );

   bpfc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(bpr_eff), .done(div_done), .quotient(div_quo), .remainder(div_rem)
   );

   // effective register values and range bounds
   assign bpr_eff  = (bpr_ff == '0) ? 17'd1 : bpr_ff;
   assign nblk     = (EW'(biu_ff) > EW'(MAX_BLOCKS)) ? EW'(MAX_BLOCKS) : EW'(biu_ff);
   assign prod     = PW'(idx_ff) * PW'(bpr_eff);
   assign en_sum   = st_ff + PW'(bpr_eff);
   assign en_c     = (en_sum < PW'(nblk)) ? en_sum : PW'(nblk);
   assign sl_c     = (st_ff < en_c) ? st_ff : en_c;
   assign last_c   = en_c - PW'(1);
   assign range_ok = (32'(idx_ff) < MAX_RANGES) && (st_ff < PW'(nblk));
   assign r_onehot = MAX_RANGES'(1) << idx_ff[RAW-1:0];
   assign cur_mask = bpfc_pkg::span_mask(lo6_ff, (wd_ff == wend_ff) ? hi6_ff : 6'd63);
   assign blk_onehot = 64'(1) << blk_ff[5:0];
   assign cur_bit  = pres_rd[blk_ff[5:0]];

   // queue index arithmetic
   assign tail_sum = TW'(head_ff) + TW'(count_ff);
   assign tail     = SW'((tail_sum >= TW'(MAX_JOBS)) ? tail_sum - TW'(MAX_JOBS) : tail_sum);
   assign slot_inc = (32'(slot_ff) == MAX_JOBS - 1) ? '0 : slot_ff + SW'(1);
   assign last_job = (CW'(jn_ff + CW'(1)) == count_ff);

   // start list merge with the current item
   always_comb begin
      lmask = list_open_ff ? list_mask_ff : '0;
      if (range_ok) begin
         lmask = lmask | r_onehot;
      end
      lbad = (list_open_ff & list_bad_ff) | !range_ok;
      lcom = list_open_ff ? list_commit_ff : req_ff.commit_id;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      ans_in         = ans_ff;
      cnt_in         = cnt_ff;
      bout_in        = bout_ff;
      bval_in        = bval_ff;
      stat_in        = stat_ff;
      bpr_in         = bpr_ff;
      biu_in         = biu_ff;
      blk_in         = blk_ff;
      rr_in          = rr_ff;
      off_in         = off_ff;
      idx_in         = idx_ff;
      st_in          = st_ff;
      wd_in          = wd_ff;
      wend_in        = wend_ff;
      lo6_in         = lo6_ff;
      hi6_in         = hi6_ff;
      slot_in        = slot_ff;
      jn_in          = jn_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      newest_in      = newest_ff;
      base_set_in    = base_set_ff;
      list_open_in   = list_open_ff;
      list_bad_in    = list_bad_ff;
      list_commit_in = list_commit_ff;
      list_mask_in   = list_mask_ff;
      clr_in         = clr_ff;
      push_en        = 1'b0;
      push_commit    = lcom;
      push_mask      = lmask;
      jbase_en       = 1'b0;
      pres_we        = 1'b0;
      pres_wa        = wd_ff;
      pres_wd        = '0;
      pres_ra        = wd_ff;
      add_we         = 1'b0;
      add_wa         = {slot_ff, wd_ff};
      add_wd         = '0;
      add_ra         = {slot_ff, wd_ff};
      base_we        = 1'b0;
      base_wa        = idx_ff[RAW-1:0];
      base_wd        = req_ff.new_baseline;
      base_ra        = idx_ff[RAW-1:0];
      div_start      = 1'b0;
      div_dividend   = (req_ff.opcode == bpfc_pkg::OP_ADD) ? req_ff.block_index
                                                           : req_ff.first_block;
      req_stall      = (state_ff != bpfc_pkg::S_IDLE);

      // register writes
      if (csr_valid) begin
         case (csr_index)
            bpfc_pkg::CSR_BPR: bpr_in = csr_wdata;
            bpfc_pkg::CSR_BIU: biu_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         // zero both bitmap rams after reset
         bpfc_pkg::S_CLEAR: begin
            pres_we = 1'b1;
            pres_wa = clr_ff[WAW-1:0];
            add_we  = 1'b1;
            add_wa  = clr_ff;
            clr_in  = clr_ff + CLW'(1);
            if (&clr_ff) begin
               state_in = bpfc_pkg::S_IDLE;
            end
         end

         bpfc_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               ans_in   = 1'b0;
               cnt_in   = '0;
               bout_in  = '0;
               bval_in  = 1'b0;
               stat_in  = bpfc_pkg::ST_OK;
               state_in = bpfc_pkg::S_DECODE;
            end
         end

         bpfc_pkg::S_DECODE: begin
            idx_in  = MIW'(req_ff.range_index);
            slot_in = head_ff;
            jn_in   = '0;
            wd_in   = '0;
            case (req_ff.opcode)
               bpfc_pkg::OP_QUERY: begin
                  if (EW'(req_ff.last_block) >= nblk) begin
                     stat_in  = bpfc_pkg::ST_RANGE;
                     state_in = bpfc_pkg::S_DONE;
                  end else if (req_ff.first_block > req_ff.last_block) begin
                     state_in = bpfc_pkg::S_DONE;
                  end else begin
                     div_start = 1'b1;
                     blk_in    = req_ff.first_block;
                     state_in  = bpfc_pkg::S_DIVIDE;
                  end
               end
               bpfc_pkg::OP_ADD: begin
                  blk_in = req_ff.block_index;
                  wd_in  = WAW'(req_ff.block_index[15:6]);
                  if (EW'(req_ff.block_index) >= nblk) begin
                     stat_in  = bpfc_pkg::ST_RANGE;
                     state_in = bpfc_pkg::S_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = bpfc_pkg::S_DIVIDE;
                  end
               end
               bpfc_pkg::OP_COUNT, bpfc_pkg::OP_START,
               bpfc_pkg::OP_GET_BASE, bpfc_pkg::OP_SET_BASE: begin
                  state_in = bpfc_pkg::S_MULT;
               end
               bpfc_pkg::OP_FINISH: begin
                  idx_in = '0;
                  if (count_ff == '0) begin
                     stat_in  = bpfc_pkg::ST_EMPTY;
                     state_in = bpfc_pkg::S_DONE;
                  end else begin
                     state_in = bpfc_pkg::S_F_RANGE;
                  end
               end
               bpfc_pkg::OP_FAIL: begin
                  if (count_ff == '0) begin
                     stat_in  = bpfc_pkg::ST_EMPTY;
                     state_in = bpfc_pkg::S_DONE;
                  end else begin
                     state_in = bpfc_pkg::S_WIPE;
                  end
               end
               bpfc_pkg::OP_UPDATE: begin
                  if (count_ff == '0) begin
                     stat_in  = bpfc_pkg::ST_EMPTY;
                     state_in = bpfc_pkg::S_DONE;
                  end else begin
                     state_in = bpfc_pkg::S_UPDATE;
                  end
               end
               default: state_in = bpfc_pkg::S_DONE;
            endcase
         end

         // block to range and offset
         bpfc_pkg::S_DIVIDE: begin
            if (div_done) begin
               rr_in  = div_quo;
               off_in = div_rem;
               state_in = (req_ff.opcode == bpfc_pkg::OP_ADD) ? bpfc_pkg::S_A_READ
                                                              : bpfc_pkg::S_Q_READ;
            end
         end

         // query walk, a read state and an evaluate state per block
         bpfc_pkg::S_Q_READ: begin
            pres_ra = WAW'(blk_ff[15:6]);
            base_ra = rr_ff[RAW-1:0];
            if (32'(rr_ff) >= MAX_RANGES) begin
               stat_in  = bpfc_pkg::ST_RANGE;
               ans_in   = 1'b0;
               state_in = bpfc_pkg::S_DONE;
            end else begin
               state_in = bpfc_pkg::S_Q_EVAL;
            end
         end

         bpfc_pkg::S_Q_EVAL: begin
            if (!base_set_ff[rr_ff[RAW-1:0]] || cur_bit || (base_rd > req_ff.commit_id)) begin
               ans_in   = 1'b1;
               state_in = bpfc_pkg::S_DONE;
            end else if (blk_ff == req_ff.last_block) begin
               state_in = bpfc_pkg::S_DONE;
            end else begin
               blk_in = blk_ff + 16'd1;
               if (off_ff + 17'd1 == bpr_eff) begin
                  off_in = '0;
                  rr_in  = rr_ff + 16'd1;
               end else begin
                  off_in = off_ff + 17'd1;
               end
               state_in = bpfc_pkg::S_Q_READ;
            end
         end

         // add: presence read, modify, write
         bpfc_pkg::S_A_READ: begin
            base_ra = rr_ff[RAW-1:0];
            if (32'(rr_ff) >= MAX_RANGES) begin
               stat_in  = bpfc_pkg::ST_RANGE;
               state_in = bpfc_pkg::S_DONE;
            end else begin
               state_in = bpfc_pkg::S_A_EVAL;
            end
         end

         bpfc_pkg::S_A_EVAL: begin
            if ((!base_set_ff[rr_ff[RAW-1:0]] || (base_rd <= req_ff.commit_id)) && !cur_bit) begin
               pres_we = 1'b1;
               pres_wd = pres_rd | blk_onehot;
               ans_in  = 1'b1;
            end
            state_in = (count_ff == '0) ? bpfc_pkg::S_DONE : bpfc_pkg::S_A_JOB;
         end

         // record the block in each matching queued job
         bpfc_pkg::S_A_JOB: begin
            if ((job_base_ff[slot_ff] <= req_ff.commit_id)
                && job_mask_ff[slot_ff][rr_ff[RAW-1:0]]) begin
               state_in = bpfc_pkg::S_A_JOB_WR;
            end else if (last_job) begin
               state_in = bpfc_pkg::S_DONE;
            end else begin
               jn_in   = jn_ff + CW'(1);
               slot_in = slot_inc;
            end
         end

         bpfc_pkg::S_A_JOB_WR: begin
            add_we = 1'b1;
            add_wd = add_rd | blk_onehot;
            if (last_job) begin
               state_in = bpfc_pkg::S_DONE;
            end else begin
               jn_in    = jn_ff + CW'(1);
               slot_in  = slot_inc;
               state_in = bpfc_pkg::S_A_JOB;
            end
         end

         bpfc_pkg::S_MULT: begin
            st_in    = prod;
            state_in = bpfc_pkg::S_CHECK;
         end

         // range checked operations
         bpfc_pkg::S_CHECK: begin
            wd_in   = sl_c[WAW+5:6];
            lo6_in  = sl_c[5:0];
            wend_in = last_c[WAW+5:6];
            hi6_in  = last_c[5:0];
            case (req_ff.opcode)
               bpfc_pkg::OP_COUNT: begin
                  if (!range_ok) begin
                     stat_in  = bpfc_pkg::ST_RANGE;
                     state_in = bpfc_pkg::S_DONE;
                  end else begin
                     state_in = bpfc_pkg::S_C_READ;
                  end
               end
               bpfc_pkg::OP_GET_BASE: begin
                  if (!range_ok) begin
                     stat_in  = bpfc_pkg::ST_RANGE;
                     state_in = bpfc_pkg::S_DONE;
                  end else if (base_set_ff[idx_ff[RAW-1:0]]) begin
                     bval_in  = 1'b1;
                     state_in = bpfc_pkg::S_G_WAIT;
                  end else begin
                     state_in = bpfc_pkg::S_DONE;
                  end
               end
               bpfc_pkg::OP_SET_BASE: begin
                  if (!range_ok) begin
                     stat_in = bpfc_pkg::ST_RANGE;
                  end else begin
                     base_we = 1'b1;
                     base_set_in[idx_ff[RAW-1:0]] = 1'b1;
                  end
                  state_in = bpfc_pkg::S_DONE;
               end
               default: begin
                  // start list item
                  if (!req_ff.list_last) begin
                     list_open_in   = 1'b1;
                     list_bad_in    = lbad;
                     list_commit_in = lcom;
                     list_mask_in   = lmask;
                     stat_in = range_ok ? bpfc_pkg::ST_OK : bpfc_pkg::ST_RANGE;
                  end else begin
                     list_open_in = 1'b0;
                     list_bad_in  = 1'b0;
                     if (32'(count_ff) >= MAX_JOBS) begin
                        stat_in = bpfc_pkg::ST_FULL;
                     end else if ((count_ff != '0) && (newest_ff >= lcom)) begin
                        stat_in = bpfc_pkg::ST_ORDER;
                     end else if (lbad) begin
                        stat_in = bpfc_pkg::ST_RANGE;
                     end else begin
                        push_en   = 1'b1;
                        count_in  = count_ff + CW'(1);
                        newest_in = lcom;
                        stat_in   = bpfc_pkg::ST_OK;
                     end
                  end
                  state_in = bpfc_pkg::S_DONE;
               end
            endcase
         end

         bpfc_pkg::S_G_WAIT: begin
            bout_in  = base_rd;
            state_in = bpfc_pkg::S_DONE;
         end

         // count walk over the words of a range
         bpfc_pkg::S_C_READ: begin
            state_in = bpfc_pkg::S_C_ACC;
         end

         bpfc_pkg::S_C_ACC: begin
            cnt_in = cnt_ff + 17'(bpfc_pkg::pop_count(pres_rd & cur_mask));
            lo6_in = '0;
            if (wd_ff == wend_ff) begin
               state_in = bpfc_pkg::S_DONE;
            end else begin
               wd_in    = wd_ff + WAW'(1);
               state_in = bpfc_pkg::S_C_READ;
            end
         end

         // finish: visit every range slot of the head job
         bpfc_pkg::S_F_RANGE: begin
            if (32'(idx_ff) >= MAX_RANGES) begin
               wd_in    = '0;
               state_in = bpfc_pkg::S_F_MREAD;
            end else if (job_mask_ff[slot_ff][idx_ff[RAW-1:0]]) begin
               state_in = bpfc_pkg::S_F_MULT;
            end else begin
               idx_in = idx_ff + MIW'(1);
            end
         end

         bpfc_pkg::S_F_MULT: begin
            st_in    = prod;
            state_in = bpfc_pkg::S_F_BOUND;
         end

         bpfc_pkg::S_F_BOUND: begin
            base_we = 1'b1;
            base_wd = job_base_ff[slot_ff];
            base_set_in[idx_ff[RAW-1:0]] = 1'b1;
            wd_in   = sl_c[WAW+5:6];
            lo6_in  = sl_c[5:0];
            wend_in = last_c[WAW+5:6];
            hi6_in  = last_c[5:0];
            if (sl_c < en_c) begin
               state_in = bpfc_pkg::S_F_READ;
            end else begin
               idx_in   = idx_ff + MIW'(1);
               state_in = bpfc_pkg::S_F_RANGE;
            end
         end

         bpfc_pkg::S_F_READ: begin
            state_in = bpfc_pkg::S_F_WRITE;
         end

         bpfc_pkg::S_F_WRITE: begin
            pres_we = 1'b1;
            pres_wd = pres_rd & ~cur_mask;
            lo6_in  = '0;
            if (wd_ff == wend_ff) begin
               idx_in   = idx_ff + MIW'(1);
               state_in = bpfc_pkg::S_F_RANGE;
            end else begin
               wd_in    = wd_ff + WAW'(1);
               state_in = bpfc_pkg::S_F_READ;
            end
         end

         // replay the added blocks, clearing them as we go
         bpfc_pkg::S_F_MREAD: begin
            state_in = bpfc_pkg::S_F_MWRITE;
         end

         bpfc_pkg::S_F_MWRITE: begin
            pres_we = 1'b1;
            pres_wd = pres_rd | add_rd;
            add_we  = 1'b1;
            if (32'(wd_ff) == NWORDS - 1) begin
               head_in  = slot_inc;
               count_in = count_ff - CW'(1);
               state_in = bpfc_pkg::S_DONE;
            end else begin
               wd_in    = wd_ff + WAW'(1);
               state_in = bpfc_pkg::S_F_MREAD;
            end
         end

         // fail: drop the head job and wipe its added blocks
         bpfc_pkg::S_WIPE: begin
            add_we = 1'b1;
            if (32'(wd_ff) == NWORDS - 1) begin
               head_in  = slot_inc;
               count_in = count_ff - CW'(1);
               state_in = bpfc_pkg::S_DONE;
            end else begin
               wd_in = wd_ff + WAW'(1);
            end
         end

         // update: oldest job with a matching commit
         bpfc_pkg::S_UPDATE: begin
            if (job_commit_ff[slot_ff] == req_ff.commit_id) begin
               jbase_en = 1'b1;
               state_in = bpfc_pkg::S_DONE;
            end else if (last_job) begin
               stat_in  = bpfc_pkg::ST_MISSING;
               state_in = bpfc_pkg::S_DONE;
            end else begin
               jn_in   = jn_ff + CW'(1);
               slot_in = slot_inc;
            end
         end

         // hand the word to the output register
         bpfc_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.answer_flag    = ans_ff;
               rsp_in.set_count      = cnt_ff;
               rsp_in.baseline_out   = bout_ff;
               rsp_in.baseline_valid = bval_ff;
               rsp_in.status         = stat_ff;
               rsp_valid_in          = 1'b1;
               state_in              = bpfc_pkg::S_IDLE;
            end
         end

         default: state_in = bpfc_pkg::S_IDLE;
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpfc_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
         bpr_ff       <= bpfc_pkg::BPR_RESET;
         biu_ff       <= bpfc_pkg::BIU_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         base_set_ff  <= '0;
         list_open_ff <= 1'b0;
         list_bad_ff  <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bpr_ff       <= bpr_in;
         biu_ff       <= biu_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         base_set_ff  <= base_set_in;
         list_open_ff <= list_open_in;
         list_bad_ff  <= list_bad_in;
         clr_ff       <= clr_in;
      end
      req_ff         <= req_in;
      rsp_ff         <= rsp_in;
      ans_ff         <= ans_in;
      cnt_ff         <= cnt_in;
      bout_ff        <= bout_in;
      bval_ff        <= bval_in;
      stat_ff        <= stat_in;
      blk_ff         <= blk_in;
      rr_ff          <= rr_in;
      off_ff         <= off_in;
      idx_ff         <= idx_in;
      st_ff          <= st_in;
      wd_ff          <= wd_in;
      wend_ff        <= wend_in;
      lo6_ff         <= lo6_in;
      hi6_ff         <= hi6_in;
      slot_ff        <= slot_in;
      jn_ff          <= jn_in;
      newest_ff      <= newest_in;
      list_commit_ff <= list_commit_in;
      list_mask_ff   <= list_mask_in;
   end

   // queue entry writes
   always_ff @(posedge clock) begin
      if (push_en) begin
         job_commit_ff[tail] <= push_commit;
         job_base_ff[tail]   <= push_commit;
         job_mask_ff[tail]   <= push_mask;
      end
      if (jbase_en) begin
         job_base_ff[slot_ff] <= req_ff.new_baseline;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

@@ src/bpfc_chk.sv @@
// port level checks of the block presence filter, bound to the top level
`include "assert_macros.svh"

module bpfc_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bpfc_pkg::rsp_type rsp_data
);

   // one request in flight: an accepted word closes the input
   `BPFC_CHECK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // the clearing pass keeps the input closed right after reset
   `BPFC_CHECK(a_clear_after_reset, $fell(reset) |-> req_stall)

   // a new result only comes out of a busy cycle
   `BPFC_CHECK(a_result_from_work, $rose(rsp_valid) |-> $past(req_stall))

   // a stalled result stays and holds its word
   `BPFC_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `BPFC_CHECK_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data))

endmodule

bind block_presence_filter_with_compaction bpfc_chk u_bpfc_chk (.*);
